// ===== hdl/knti_pkg.sv =====
// Shared types, character codes and arithmetic constants of the kanji numeral parser.
`default_nettype none

package knti_pkg;

   // Depth of the queue between the classifying front and the arithmetic back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int CODE_W  = 24;
   localparam int GROUP_W = 32;
   localparam int MAG_W   = 64;
   localparam int POW_W   = 54;
   localparam int HALF_W  = 27;
   localparam int PART_W  = GROUP_W + HALF_W;

   // UTF-8 byte triples of the recognized characters.
   localparam logic [CODE_W-1:0] CH_REI   = 24'hE99BB6;
   localparam logic [CODE_W-1:0] CH_ICHI  = 24'hE4B880;
   localparam logic [CODE_W-1:0] CH_NI    = 24'hE4BA8C;
   localparam logic [CODE_W-1:0] CH_SAN   = 24'hE4B889;
   localparam logic [CODE_W-1:0] CH_YON   = 24'hE59B9B;
   localparam logic [CODE_W-1:0] CH_GO    = 24'hE4BA94;
   localparam logic [CODE_W-1:0] CH_ROKU  = 24'hE585AD;
   localparam logic [CODE_W-1:0] CH_NANA  = 24'hE4B883;
   localparam logic [CODE_W-1:0] CH_HACHI = 24'hE585AB;
   localparam logic [CODE_W-1:0] CH_KYU   = 24'hE4B99D;
   localparam logic [CODE_W-1:0] CH_JU    = 24'hE58D81;
   localparam logic [CODE_W-1:0] CH_HYAKU = 24'hE799BE;
   localparam logic [CODE_W-1:0] CH_SEN   = 24'hE58D83;
   localparam logic [CODE_W-1:0] CH_MAN   = 24'hE4B887;
   localparam logic [CODE_W-1:0] CH_OKU   = 24'hE58484;
   localparam logic [CODE_W-1:0] CH_CHO   = 24'hE58586;
   localparam logic [CODE_W-1:0] CH_KEI   = 24'hE4BAAC;
   localparam logic [CODE_W-1:0] CH_GAI   = 24'hE59E93;
   localparam logic [CODE_W-1:0] CH_JO    = 24'hE7A7AD;
   localparam logic [CODE_W-1:0] CH_FU    = 24'hE8B2A0;

   // Multiplier indexes.
   localparam logic [3:0] MULT_TEN      = 4'd0;
   localparam logic [3:0] MULT_HUNDRED  = 4'd1;
   localparam logic [3:0] MULT_THOUSAND = 4'd2;

   // Large unit indexes; gai and jo always overflow when their group is nonzero.
   localparam logic [3:0] UNIT_MAN = 4'd0;
   localparam logic [3:0] UNIT_OKU = 4'd1;
   localparam logic [3:0] UNIT_CHO = 4'd2;
   localparam logic [3:0] UNIT_KEI = 4'd3;
   localparam logic [3:0] UNIT_GAI = 4'd4;
   localparam logic [3:0] UNIT_JO  = 4'd5;

   // Scale selects carried to the multiplier stage.
   localparam logic [2:0] POW_SEL_ONE = 3'd0;
   localparam logic [2:0] POW_SEL_MAN = 3'd1;
   localparam logic [2:0] POW_SEL_OKU = 3'd2;
   localparam logic [2:0] POW_SEL_CHO = 3'd3;
   localparam logic [2:0] POW_SEL_KEI = 3'd4;

   localparam logic [MAG_W-1:0] MAG_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [MAG_W-1:0] MAG_MAX_NEG = 64'h8000_0000_0000_0000;

   localparam logic [MAG_W-1:0] POW_MAN = 64'd10000;
   localparam logic [MAG_W-1:0] POW_OKU = 64'd100000000;
   localparam logic [MAG_W-1:0] POW_CHO = 64'd1000000000000;
   localparam logic [MAG_W-1:0] POW_KEI = 64'd10000000000000000;

   localparam logic [MAG_W-1:0] LIM_POS_MAN = MAG_MAX_POS / POW_MAN;
   localparam logic [MAG_W-1:0] LIM_POS_OKU = MAG_MAX_POS / POW_OKU;
   localparam logic [MAG_W-1:0] LIM_POS_CHO = MAG_MAX_POS / POW_CHO;
   localparam logic [MAG_W-1:0] LIM_POS_KEI = MAG_MAX_POS / POW_KEI;
   localparam logic [MAG_W-1:0] LIM_NEG_MAN = MAG_MAX_NEG / POW_MAN;
   localparam logic [MAG_W-1:0] LIM_NEG_OKU = MAG_MAX_NEG / POW_OKU;
   localparam logic [MAG_W-1:0] LIM_NEG_CHO = MAG_MAX_NEG / POW_CHO;
   localparam logic [MAG_W-1:0] LIM_NEG_KEI = MAG_MAX_NEG / POW_KEI;

   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_MULT,
      KIND_UNIT,
      KIND_FU,
      KIND_OTHER
   } kind_type;

   // One classified character as it waits in the queue.
   typedef struct packed {
      kind_type   kind;
      logic [3:0] index;
      logic       last;
   } char_item_type;

   typedef struct packed {
      logic          push;
      char_item_type item;
   } queue_wr_type;

   typedef struct packed {
      logic          valid;
      char_item_type item;
   } queue_rd_type;

   // Magnitude update handed from the group logic to the multiply/accumulate stages.
   typedef struct packed {
      logic               force_ovf;
      logic [GROUP_W-1:0] group;
      logic [2:0]         pow_sel;
      logic               finish;
      logic               neg;
   } mag_op_type;

   function automatic char_item_type classify(input logic [CODE_W-1:0] code);
      char_item_type r;
      r.kind  = KIND_OTHER;
      r.index = 4'd0;
      r.last  = 1'b0;
      unique case (code)
         CH_REI:   begin r.kind = KIND_DIGIT; r.index = 4'd0; end
         CH_ICHI:  begin r.kind = KIND_DIGIT; r.index = 4'd1; end
         CH_NI:    begin r.kind = KIND_DIGIT; r.index = 4'd2; end
         CH_SAN:   begin r.kind = KIND_DIGIT; r.index = 4'd3; end
         CH_YON:   begin r.kind = KIND_DIGIT; r.index = 4'd4; end
         CH_GO:    begin r.kind = KIND_DIGIT; r.index = 4'd5; end
         CH_ROKU:  begin r.kind = KIND_DIGIT; r.index = 4'd6; end
         CH_NANA:  begin r.kind = KIND_DIGIT; r.index = 4'd7; end
         CH_HACHI: begin r.kind = KIND_DIGIT; r.index = 4'd8; end
         CH_KYU:   begin r.kind = KIND_DIGIT; r.index = 4'd9; end
         CH_JU:    begin r.kind = KIND_MULT;  r.index = MULT_TEN; end
         CH_HYAKU: begin r.kind = KIND_MULT;  r.index = MULT_HUNDRED; end
         CH_SEN:   begin r.kind = KIND_MULT;  r.index = MULT_THOUSAND; end
         CH_MAN:   begin r.kind = KIND_UNIT;  r.index = UNIT_MAN; end
         CH_OKU:   begin r.kind = KIND_UNIT;  r.index = UNIT_OKU; end
         CH_CHO:   begin r.kind = KIND_UNIT;  r.index = UNIT_CHO; end
         CH_KEI:   begin r.kind = KIND_UNIT;  r.index = UNIT_KEI; end
         CH_GAI:   begin r.kind = KIND_UNIT;  r.index = UNIT_GAI; end
         CH_JO:    begin r.kind = KIND_UNIT;  r.index = UNIT_JO; end
         CH_FU:    begin r.kind = KIND_FU;    r.index = 4'd0; end
         default:  begin r.kind = KIND_OTHER; r.index = 4'd0; end
      endcase
      return r;
   endfunction

   // Digit times ten, hundred or thousand; at most 9000.
   function automatic logic [13:0] mult_scaled(input logic [3:0] d, input logic [3:0] sel);
      logic [13:0] r;
      unique case (sel)
         MULT_TEN:      r = 14'(d) * 14'd10;
         MULT_HUNDRED:  r = 14'(d) * 14'd100;
         MULT_THOUSAND: r = 14'(d) * 14'd1000;
         default:       r = 14'd0;
      endcase
      return r;
   endfunction

   function automatic logic [GROUP_W-1:0] sat_add32(input logic [GROUP_W-1:0] a,
                                                    input logic [GROUP_W-1:0] b);
      logic [GROUP_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[GROUP_W] ? {GROUP_W{1'b1}} : s[GROUP_W-1:0];
   endfunction

   // Largest group that a unit may scale without leaving the magnitude range.
   function automatic logic [MAG_W-1:0] unit_limit(input logic [3:0] idx, input logic neg);
      logic [MAG_W-1:0] r;
      unique case (idx)
         UNIT_MAN: r = neg ? LIM_NEG_MAN : LIM_POS_MAN;
         UNIT_OKU: r = neg ? LIM_NEG_OKU : LIM_POS_OKU;
         UNIT_CHO: r = neg ? LIM_NEG_CHO : LIM_POS_CHO;
         UNIT_KEI: r = neg ? LIM_NEG_KEI : LIM_POS_KEI;
         default:  r = {MAG_W{1'b0}};
      endcase
      return r;
   endfunction

   function automatic logic [POW_W-1:0] pow_value(input logic [2:0] sel);
      logic [MAG_W-1:0] r;
      unique case (sel)
         POW_SEL_ONE: r = 64'd1;
         POW_SEL_MAN: r = POW_MAN;
         POW_SEL_OKU: r = POW_OKU;
         POW_SEL_CHO: r = POW_CHO;
         POW_SEL_KEI: r = POW_KEI;
         default:     r = 64'd0;
      endcase
      return r[POW_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/knti_req_if.sv =====
// Request channel of the kanji numeral parser: one character per request.
`default_nettype none

interface knti_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] char_code;
   logic        last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ===== hdl/knti_rsp_if.sv =====
// Response channel of the kanji numeral parser: one signed value per numeral.
`default_nettype none

interface knti_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               overflow;

   modport source (output valid, output value, output overflow, input ready);
   modport sink   (input valid, input value, input overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/knti_front.sv =====
// Front end: takes requests while the queue has room and classifies each character.
`default_nettype none

module knti_front
   import knti_pkg::*;
(
   knti_req_if.sink     req,
   input  logic         queue_full,
   output queue_wr_type queue_wr
);

   char_item_type item;

   always_comb begin
      item      = classify(req.char_code);
      item.last = req.last_char;
   end

   assign req.ready     = !queue_full;
   assign queue_wr.push = req.valid && !queue_full;
   assign queue_wr.item = item;

endmodule

`default_nettype wire

// ===== hdl/knti_queue.sv =====
// Short queue of classified characters between the front end and the back end.
`default_nettype none

module knti_queue
   import knti_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type queue_wr,
   output logic         queue_full,
   output queue_rd_type queue_rd,
   input  logic         queue_pop
);

   char_item_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W:0]   rd_ptr_ff, rd_ptr_in;
   logic                   empty;

   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign queue_full = (wr_ptr_ff[QUEUE_PTR_W] != rd_ptr_ff[QUEUE_PTR_W])
                    && (wr_ptr_ff[QUEUE_PTR_W-1:0] == rd_ptr_ff[QUEUE_PTR_W-1:0]);

   assign queue_rd.valid = !empty;
   assign queue_rd.item  = entry_ff[rd_ptr_ff[QUEUE_PTR_W-1:0]];

   assign wr_ptr_in = wr_ptr_ff + (QUEUE_PTR_W+1)'(queue_wr.push);
   assign rd_ptr_in = rd_ptr_ff + (QUEUE_PTR_W+1)'(queue_pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         entry_ff[wr_ptr_ff[QUEUE_PTR_W-1:0]] <= queue_wr.item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/knti_back.sv =====
// Back end: group arithmetic, scaled multiply, saturating accumulate and the response register.
`default_nettype none

module knti_back
   import knti_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_rd_type queue_rd,
   output logic         queue_pop,
   knti_rsp_if.source   rsp
);

   // Group stage state.
   logic [3:0]         pend_digit_ff, pend_digit_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic               neg_ff, neg_in;
   logic               at_start_ff, at_start_in;

   // Pipeline registers.
   logic               s1_valid_ff, s1_valid_in;
   mag_op_type         s1_op_ff, s1_op_in;
   logic               s2_valid_ff;
   logic [PART_W-1:0]  s2_lo_ff, s2_hi_ff, s2_lo_in, s2_hi_in;
   logic               s2_force_ff, s2_finish_ff, s2_neg_ff;
   logic               s3_valid_ff;
   logic [MAG_W-1:0]   s3_prod_ff, s3_prod_in;
   logic               s3_force_ff, s3_finish_ff, s3_neg_ff;

   // Running magnitude.
   logic [MAG_W-1:0]   total_ff, total_in;
   logic               ovf_ff, ovf_in;

   // Finished numeral waiting for the response register.
   logic               fin_valid_ff, fin_valid_in;
   logic [MAG_W-1:0]   fin_total_ff, fin_total_in;
   logic               fin_ovf_ff, fin_ovf_in, fin_neg_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_ovf_ff;

   logic               rsp_free;
   logic               stall;

   kind_type           eff_kind;
   logic               fu_first;
   logic               neg_now;
   logic [GROUP_W-1:0] g1;
   logic [3:0]         mult_d;
   logic               emit;
   logic [POW_W-1:0]   pow;
   logic [MAG_W:0]     acc_sum;
   logic [MAG_W-1:0]   mag_lim;
   logic [MAG_W-1:0]   acc_total;
   logic               acc_ovf;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign stall     = fin_valid_ff && !rsp_free;
   assign queue_pop = queue_rd.valid && !stall;

   // Group stage: pending digit, group sum and sign.
   always_comb begin
      fu_first = at_start_ff && (queue_rd.item.kind == KIND_FU);
      eff_kind = (queue_rd.item.kind == KIND_FU && !at_start_ff) ? KIND_OTHER
                                                                  : queue_rd.item.kind;
      neg_now  = neg_ff || fu_first;
      g1       = sat_add32(group_ff, pend_valid_ff ? GROUP_W'(pend_digit_ff) : '0);
      mult_d   = pend_valid_ff ? pend_digit_ff : 4'd1;

      pend_digit_in = 4'd0;
      pend_valid_in = 1'b0;
      group_in      = g1;
      emit          = queue_rd.item.last;

      s1_op_in.force_ovf = 1'b0;
      s1_op_in.group     = g1;
      s1_op_in.pow_sel   = POW_SEL_ONE;
      s1_op_in.finish    = queue_rd.item.last;
      s1_op_in.neg       = neg_now;

      unique case (eff_kind)
         KIND_FU: begin
            pend_digit_in = pend_digit_ff;
            pend_valid_in = pend_valid_ff;
            group_in      = group_ff;
         end
         KIND_DIGIT: begin
            pend_digit_in = queue_rd.item.index;
            pend_valid_in = 1'b1;
         end
         KIND_MULT: begin
            group_in = sat_add32(group_ff,
                                 GROUP_W'(mult_scaled(mult_d, queue_rd.item.index)));
         end
         KIND_UNIT: begin
            group_in = '0;
            if (g1 != '0) begin
               emit = 1'b1;
               if (queue_rd.item.index >= UNIT_GAI) begin
                  s1_op_in.force_ovf = 1'b1;
               end else if (MAG_W'(g1) > unit_limit(queue_rd.item.index, neg_now)) begin
                  s1_op_in.force_ovf = 1'b1;
               end else begin
                  s1_op_in.pow_sel = 3'(queue_rd.item.index[1:0]) + 3'd1;
               end
            end
         end
         KIND_OTHER: begin
            group_in = g1;
         end
         default: begin
            group_in = g1;
         end
      endcase

      // The last character, unless it is a large unit, flushes the group into the magnitude at scale one.
      if (queue_rd.item.last && eff_kind != KIND_UNIT) begin
         s1_op_in.group = sat_add32(group_in,
                                    pend_valid_in ? GROUP_W'(pend_digit_in) : '0);
      end

      if (queue_rd.item.last) begin
         pend_digit_in = 4'd0;
         pend_valid_in = 1'b0;
         group_in      = '0;
         neg_in        = 1'b0;
         at_start_in   = 1'b1;
      end else begin
         neg_in        = neg_now;
         at_start_in   = 1'b0;
      end

      s1_valid_in = emit;
   end

   // Multiply stage: group times the scale in two partial products.
   always_comb begin
      pow      = pow_value(s1_op_ff.pow_sel);
      s2_lo_in = PART_W'(s1_op_ff.group) * PART_W'(pow[HALF_W-1:0]);
      s2_hi_in = PART_W'(s1_op_ff.group) * PART_W'(pow[POW_W-1:HALF_W]);
   end

   assign s3_prod_in = MAG_W'({s2_hi_ff, {HALF_W{1'b0}}}) + MAG_W'(s2_lo_ff);

   // Accumulate stage: saturating add into the magnitude.
   always_comb begin
      mag_lim = s3_neg_ff ? MAG_MAX_NEG : MAG_MAX_POS;
      acc_sum = {1'b0, total_ff} + {1'b0, s3_prod_ff};
      if (ovf_ff) begin
         acc_total = total_ff;
         acc_ovf   = 1'b1;
      end else if (s3_force_ff || acc_sum > {1'b0, mag_lim}) begin
         acc_total = mag_lim;
         acc_ovf   = 1'b1;
      end else begin
         acc_total = acc_sum[MAG_W-1:0];
         acc_ovf   = 1'b0;
      end

      total_in     = total_ff;
      ovf_in       = ovf_ff;
      fin_valid_in = fin_valid_ff && !rsp_free;
      fin_total_in = acc_total;
      fin_ovf_in   = acc_ovf;
      if (!stall) begin
         fin_valid_in = s3_valid_ff && s3_finish_ff;
         if (s3_valid_ff) begin
            if (s3_finish_ff) begin
               total_in = '0;
               ovf_in   = 1'b0;
            end else begin
               total_in = acc_total;
               ovf_in   = acc_ovf;
            end
         end
      end
   end

   assign rsp_valid_in = rsp_free ? fin_valid_ff : rsp_valid_ff;
   assign rsp_value_in = fin_neg_ff ? (MAG_W'(0) - fin_total_ff) : fin_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_digit_ff <= 4'd0;
         pend_valid_ff <= 1'b0;
         group_ff      <= '0;
         neg_ff        <= 1'b0;
         at_start_ff   <= 1'b1;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         fin_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (queue_pop) begin
            pend_digit_ff <= pend_digit_in;
            pend_valid_ff <= pend_valid_in;
            group_ff      <= group_in;
            neg_ff        <= neg_in;
            at_start_ff   <= at_start_in;
         end
         if (!stall) begin
            s1_valid_ff <= queue_pop && s1_valid_in;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_op_ff     <= s1_op_in;
         s2_lo_ff     <= s2_lo_in;
         s2_hi_ff     <= s2_hi_in;
         s2_force_ff  <= s1_op_ff.force_ovf;
         s2_finish_ff <= s1_op_ff.finish;
         s2_neg_ff    <= s1_op_ff.neg;
         s3_prod_ff   <= s3_prod_in;
         s3_force_ff  <= s2_force_ff;
         s3_finish_ff <= s2_finish_ff;
         s3_neg_ff    <= s2_neg_ff;
         fin_total_ff <= fin_total_in;
         fin_ovf_ff   <= fin_ovf_in;
         fin_neg_ff   <= s3_neg_ff;
      end
      if (rsp_free) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ovf_ff   <= fin_ovf_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.value    = $signed(rsp_value_ff);
   assign rsp.overflow = rsp_ovf_ff;

   // A finished numeral is never dropped while the response register is blocked.
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && rsp_valid_ff && !rsp.ready) |=> fin_valid_ff)
      else $error("finished numeral lost while response stalled");

   // The magnitude never goes beyond two to the sixty-third.
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      (!total_ff[MAG_W-1] || total_ff[MAG_W-2:0] == '0))
      else $error("magnitude beyond range");

   // Flushing a numeral returns the accumulator to zero.
   a_total_clear: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_finish_ff && !stall) |=> (total_ff == '0 && !ovf_ff))
      else $error("accumulator not cleared after a numeral");

   // An overflowed result is one of the two saturated extremes.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |->
         (rsp_value_ff == MAG_MAX_POS || rsp_value_ff == MAG_MAX_NEG))
      else $error("overflow without saturated value");

endmodule

`default_nettype wire

// ===== hdl/kanji_numeral_to_integer.sv =====
// Top level of the kanji numeral parser: front end, character queue and arithmetic back end.
//
// Usage. Each request on req carries one character of a kanji numeral as its three UTF-8
// bytes in req.char_code (first byte in bits 23 to 16) and req.last_char, which marks the
// final character. Only a request with last_char set yields a response on rsp: the signed
// value of the whole numeral and an overflow flag; when the magnitude leaves the signed
// 64-bit range the value sticks at the extreme of its sign.
// Throughput: one request per clock cycle, sustained, for as long as responses are taken.
// A final character, once accepted, passes the queue entry, the group stage, two multiply
// stages, the accumulate stage and the response register before its response is valid.
// A four-entry queue parts the classifying front end from the back end, so requests keep
// being taken while a response waits. When rsp.ready stays low, one finished numeral waits
// behind the response register, then the back end holds and, once the queue is full,
// req.ready falls.
// Reset is synchronous and active high; it empties the queue and the pipeline and returns
// the parser to the start of a numeral. No clearing pass is needed afterwards.
`default_nettype none

module kanji_numeral_to_integer
   import knti_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   knti_req_if.sink   req,
   knti_rsp_if.source rsp
);

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         queue_pop;

   // Classification happens as the request is taken; only the class, its index and the last flag travel on.
   knti_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   // The queue lets the front end keep accepting while the back end is held.
   knti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_rd   (queue_rd),
      .queue_pop  (queue_pop)
   );

   // The back end retires one character per cycle unless its output is blocked.
   knti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_rd  (queue_rd),
      .queue_pop (queue_pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== test/knti_checker.sv =====
// Checker for the kanji numeral parser: follows each numeral and compares every response.
`timescale 1ns / 1ps

module knti_checker
   import knti_pkg::*;
(
   input  logic clock,
   input  logic reset,
   knti_req_if  req_mon,
   knti_rsp_if  rsp_mon,
   output int   error_count,
   output int   results_owed
);

   typedef struct packed {
      logic signed [63:0] value;
      logic               overflow;
   } numeral_result_t;

   // Parse state of the numeral currently arriving.
   logic [3:0]  held_digit;
   logic        held_valid;
   logic [31:0] group_acc;
   logic [63:0] magnitude;
   logic        is_negative;
   logic        first_char;
   logic        saturated;

   numeral_result_t numeral_results_q[$];

   function automatic void restart_numeral();
      held_digit  = 4'd0;
      held_valid  = 1'b0;
      group_acc   = 32'd0;
      magnitude   = 64'd0;
      is_negative = 1'b0;
      first_char  = 1'b1;
      saturated   = 1'b0;
   endfunction

   function automatic logic [63:0] mag_ceiling();
      return is_negative ? MAG_MAX_NEG : MAG_MAX_POS;
   endfunction

   function automatic void clip_magnitude();
      saturated = 1'b1;
      magnitude = mag_ceiling();
   endfunction

   function automatic void accumulate(input logic [63:0] addend);
      if (!saturated) begin
         if (addend > mag_ceiling() - magnitude) begin
            clip_magnitude();
         end else begin
            magnitude = magnitude + addend;
         end
      end
   endfunction

   function automatic void group_plus(input logic [31:0] addend);
      if (addend > 32'hFFFF_FFFF - group_acc) begin
         group_acc = 32'hFFFF_FFFF;
      end else begin
         group_acc = group_acc + addend;
      end
   endfunction

   function automatic void commit_digit();
      if (held_valid) begin
         group_plus(32'(held_digit));
      end
      held_valid = 1'b0;
      held_digit = 4'd0;
   endfunction

   function automatic void consume_char(input logic [23:0] code);
      int          digit_val;
      int          unit_rank;
      logic [31:0] scale;
      logic [63:0] scale_pow;
      if (first_char) begin
         first_char = 1'b0;
         if (code == CH_FU) begin
            is_negative = 1'b1;
            return;
         end
      end
      digit_val = -1;
      unit_rank = -1;
      scale     = 32'd0;
      case (code)
         CH_REI:   digit_val = 0;
         CH_ICHI:  digit_val = 1;
         CH_NI:    digit_val = 2;
         CH_SAN:   digit_val = 3;
         CH_YON:   digit_val = 4;
         CH_GO:    digit_val = 5;
         CH_ROKU:  digit_val = 6;
         CH_NANA:  digit_val = 7;
         CH_HACHI: digit_val = 8;
         CH_KYU:   digit_val = 9;
         CH_JU:    scale = 32'd10;
         CH_HYAKU: scale = 32'd100;
         CH_SEN:   scale = 32'd1000;
         CH_MAN:   unit_rank = 0;
         CH_OKU:   unit_rank = 1;
         CH_CHO:   unit_rank = 2;
         CH_KEI:   unit_rank = 3;
         CH_GAI:   unit_rank = 4;
         CH_JO:    unit_rank = 5;
         default:  ;
      endcase
      if (digit_val >= 0) begin
         commit_digit();
         held_digit = 4'(digit_val);
         held_valid = 1'b1;
      end else if (scale != 0) begin
         // A multiplier with no digit in front of it counts as one of itself.
         group_plus((held_valid ? 32'(held_digit) : 32'd1) * scale);
         held_valid = 1'b0;
         held_digit = 4'd0;
      end else if (unit_rank >= 0) begin
         commit_digit();
         if (group_acc != 0) begin
            if (unit_rank >= 4) begin
               clip_magnitude();
            end else begin
               scale_pow = 64'd1;
               for (int k = 0; k <= unit_rank; k++) begin
                  scale_pow = scale_pow * 64'd10000;
               end
               if (64'(group_acc) > mag_ceiling() / scale_pow) begin
                  clip_magnitude();
               end else begin
                  accumulate(64'(group_acc) * scale_pow);
               end
            end
         end
         group_acc = 32'd0;
      end else begin
         commit_digit();
      end
   endfunction

   function automatic void close_numeral();
      numeral_result_t r;
      commit_digit();
      accumulate(64'(group_acc));
      group_acc  = 32'd0;
      r.value    = is_negative ? -magnitude : magnitude;
      r.overflow = saturated;
      numeral_results_q.push_back(r);
      restart_numeral();
   endfunction

   always @(posedge clock) begin
      numeral_result_t want;
      if (reset) begin
         restart_numeral();
         numeral_results_q.delete();
         error_count = 0;
      end else begin
         // Responses are checked before the request of the same edge is taken in,
         // since a response can never come from a request accepted at that edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (numeral_results_q.size() == 0) begin
               $error("unexpected response: value %0d overflow %0b",
                      rsp_mon.value, rsp_mon.overflow);
               error_count++;
            end else begin
               want = numeral_results_q.pop_front();
               if (rsp_mon.value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_mon.value);
                  error_count++;
               end
               if (rsp_mon.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b",
                         want.overflow, rsp_mon.overflow);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            consume_char(req_mon.char_code);
            if (req_mon.last_char) begin
               close_numeral();
            end
         end
      end
      results_owed = numeral_results_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Top of the kanji numeral parser testbench: clock, reset, request and response traffic.
`timescale 1ns / 1ps

module tb_top;
   import knti_pkg::*;

   // Run length and guard limits. The watchdog sits far above the length of the slowest
   // correct run.
   localparam int TOTAL_ITEMS  = 1700;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PCT     = 8;

   localparam logic [23:0] DIGIT_CODES [10] = '{CH_REI, CH_ICHI, CH_NI, CH_SAN, CH_YON,
                                                CH_GO, CH_ROKU, CH_NANA, CH_HACHI, CH_KYU};
   // Ordered from the largest place down: thousand, hundred, ten.
   localparam logic [23:0] SCALE_CODES [3] = '{CH_SEN, CH_HYAKU, CH_JU};
   localparam logic [23:0] UNIT_CODES [6]  = '{CH_MAN, CH_OKU, CH_CHO, CH_KEI, CH_GAI, CH_JO};
   localparam logic [23:0] KNOWN_CODES [20] = '{
      CH_REI, CH_ICHI, CH_NI, CH_SAN, CH_YON, CH_GO, CH_ROKU, CH_NANA, CH_HACHI, CH_KYU,
      CH_JU, CH_HYAKU, CH_SEN, CH_MAN, CH_OKU, CH_CHO, CH_KEI, CH_GAI, CH_JO, CH_FU};

   typedef struct {
      logic [23:0] code;
      logic        last;
   } kanji_char_t;

   logic clock;
   logic reset;

   knti_req_if req_bus ();
   knti_rsp_if rsp_bus ();

   int error_total;
   int results_owed;
   int idle_pct;
   int items_sent;
   int numeral_index;

   // Characters of the numeral being assembled before it is sent.
   kanji_char_t numeral_chars[$];

   kanji_numeral_to_integer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   knti_checker numeral_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .error_count  (error_total),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The watchdog ends a run that hangs, for example when a response never arrives.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // The response side stalls at random at the falling edge. The stall rate follows
   // idle_pct, so the quiet stretch of the run has no stalls on either side.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = reset ? 1'b0 : ($urandom_range(99) >= idle_pct);
      end
   end

   function automatic void add_char(input logic [23:0] code);
      kanji_char_t c;
      c.code = code;
      c.last = 1'b0;
      numeral_chars.push_back(c);
   endfunction

   function automatic void mark_last();
      numeral_chars[numeral_chars.size() - 1].last = 1'b1;
   endfunction

   // Writes a group below ten thousand as thousands, hundreds, tens and ones. A leading
   // one in front of a multiplier is sometimes left out, which the parser reads as one.
   function automatic void add_group(input int unsigned grp);
      int unsigned place;
      int unsigned d;
      place = 1000;
      for (int k = 0; k < 3; k++) begin
         d = (grp / place) % 10;
         if (d != 0) begin
            if (d == 1 && $urandom_range(1) == 1) begin
               add_char(SCALE_CODES[k]);
            end else begin
               add_char(DIGIT_CODES[d]);
               add_char(SCALE_CODES[k]);
            end
         end
         place = place / 10;
      end
      d = grp % 10;
      if (d != 0) begin
         // A zero digit before the ones adds nothing but goes through the digit path.
         if ($urandom_range(9) == 0) begin
            add_char(CH_REI);
         end
         add_char(DIGIT_CODES[d]);
      end
   endfunction

   // Writes a full 64-bit magnitude with the large units from kei down to man.
   // The kei group is at most 1844 in value, below ten thousand, so it stays writable.
   function automatic void add_magnitude(input logic [63:0] mag);
      logic [63:0] pw;
      int unsigned grp;
      if (mag == 64'd0) begin
         add_char(CH_REI);
         return;
      end
      for (int rank = 3; rank >= 0; rank--) begin
         pw = 64'd1;
         for (int k = 0; k <= rank; k++) begin
            pw = pw * 64'd10000;
         end
         grp = (rank == 3) ? 32'(mag / pw) : 32'((mag / pw) % 64'd10000);
         if (grp != 0) begin
            add_group(grp);
            add_char(UNIT_CODES[rank]);
         end
      end
      add_group(32'(mag % 64'd10000));
   endfunction

   // Any code at all: a recognized character, a random triple, or a recognized
   // character with one bit flipped, which is almost always unknown.
   function automatic logic [23:0] random_code();
      logic [23:0] code;
      case ($urandom_range(2))
         0:       code = KNOWN_CODES[$urandom_range(19)];
         1:       code = 24'($urandom);
         default: code = KNOWN_CODES[$urandom_range(19)] ^ (24'd1 << $urandom_range(23));
      endcase
      return code;
   endfunction

   function automatic logic [63:0] random_magnitude();
      logic [63:0] mag;
      mag = {$urandom, $urandom};
      return mag >> $urandom_range(63);
   endfunction

   // Valid rises at the falling edge and holds until the request is taken at a rising
   // edge. Random gaps are put in front of a request, never in the middle of one.
   task automatic send_char(input kanji_char_t c);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.char_code = c.code;
      req_bus.last_char = c.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_numeral();
      mark_last();
      foreach (numeral_chars[i]) begin
         send_char(numeral_chars[i]);
      end
      numeral_chars.delete();
   endtask

   // Holds the request side quiet until every numeral sent so far has its response.
   task automatic wait_for_drain();
      req_bus.valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   initial begin
      logic [63:0] edge_mags [6];
      int          pick;
      int          pos;

      edge_mags = '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                    64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'd9999999999999999, 64'd10000000000000000};

      req_bus.valid     = 1'b0;
      req_bus.char_code = 24'd0;
      req_bus.last_char = 1'b0;
      reset             = 1'b1;
      idle_pct          = IDLE_PCT;
      items_sent        = 0;
      numeral_index     = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part. Codes at both ends of the field, unknown as a whole numeral.
      add_char(24'h000000);
      send_numeral();
      add_char(24'hFFFFFF);
      send_numeral();
      // The minus sign alone gives zero.
      add_char(CH_FU);
      send_numeral();
      // A negative four-digit numeral with every multiplier scaling a digit.
      add_char(CH_FU);
      add_char(CH_KYU);
      add_char(CH_SEN);
      add_char(CH_HACHI);
      add_char(CH_HYAKU);
      add_char(CH_NANA);
      add_char(CH_JU);
      add_char(CH_ROKU);
      send_numeral();
      // Multipliers standing alone count as one each.
      add_char(CH_JU);
      add_char(CH_HYAKU);
      add_char(CH_SEN);
      send_numeral();
      // Every large unit that stays in range, then a trailing digit.
      add_char(CH_ICHI);
      add_char(CH_MAN);
      add_char(CH_NI);
      add_char(CH_OKU);
      add_char(CH_SAN);
      add_char(CH_CHO);
      add_char(CH_YON);
      add_char(CH_KEI);
      add_char(CH_GO);
      send_numeral();
      // Gai and jo with a nonzero group always overflow.
      add_char(CH_ICHI);
      add_char(CH_GAI);
      send_numeral();
      add_char(CH_FU);
      add_char(CH_ICHI);
      add_char(CH_JO);
      send_numeral();
      // The minus sign after the first place is just an unknown character.
      add_char(CH_REI);
      add_char(CH_FU);
      send_numeral();

      // Random part: mostly well-formed numerals with random values, some at the edges
      // of the signed range, some with gai or jo, the rest broken numerals and noise.
      while (items_sent < TOTAL_ITEMS) begin
         // A long stretch in the middle of the run has no idling on either side.
         idle_pct = (items_sent >= 600 && items_sent < 900) ? 0 : IDLE_PCT;
         pick = $urandom_range(99);
         if (pick < 55) begin
            if ($urandom_range(9) < 3) begin
               add_char(CH_FU);
            end
            add_magnitude(random_magnitude());
         end else if (pick < 67) begin
            if ($urandom_range(1) == 1) begin
               add_char(CH_FU);
            end
            add_magnitude(edge_mags[$urandom_range(5)]);
         end else if (pick < 74) begin
            // Gai or jo, with a group that is sometimes empty and then has no effect.
            if ($urandom_range(1) == 1) begin
               add_char(CH_FU);
            end
            add_group($urandom_range(1) == 1 ? $urandom_range(9999) : 0);
            add_char(UNIT_CODES[$urandom_range(5, 4)]);
            add_magnitude(random_magnitude() >> 32);
         end else if (pick < 84) begin
            // A well-formed numeral with one character replaced.
            add_magnitude(random_magnitude());
            pos = $urandom_range(numeral_chars.size() - 1);
            numeral_chars[pos].code = random_code();
         end else begin
            repeat ($urandom_range(6, 1)) add_char(random_code());
         end
         send_numeral();
         numeral_index++;
         if (numeral_index % 25 == 12) begin
            wait_for_drain();
         end
      end

      idle_pct = IDLE_PCT;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_total == 0 && results_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
